/* hdl/bf16_dot_product_clamp_4col_core_macros.svh */
// Assertion macros shared by the bf16 dot product core.
`ifndef BF16_DOT_PRODUCT_CLAMP_4COL_CORE_MACROS_SVH
`define BF16_DOT_PRODUCT_CLAMP_4COL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define BFDP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define BFDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define BFDP_ASSERT_IMPL(lbl, ante, cons)
`define BFDP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/bfdp_pkg.sv */
// Types, constants and float helpers for the bf16 dot product core.
package bfdp_pkg;

    localparam int NUM_LANES = 4;

    localparam logic CFG_MIN_CLAMP = 1'b0;
    localparam logic CFG_MAX_CLAMP = 1'b1;

    localparam logic [31:0] MIN_CLAMP_RESET = 32'hFF80_0000;
    localparam logic [31:0] MAX_CLAMP_RESET = 32'h7F80_0000;
    localparam logic [31:0] F32_QNAN        = 32'h7FC0_0000;

    typedef struct packed {
        logic        first;
        logic        last;
        logic [2:0]  lanes_in_use;
        logic [15:0] activation;
        logic [15:0] weight0;
        logic [15:0] weight1;
        logic [15:0] weight2;
        logic [15:0] weight3;
        logic [31:0] bias0;
        logic [31:0] bias1;
        logic [31:0] bias2;
        logic [31:0] bias3;
    } in_t;

    typedef struct packed {
        logic [31:0] result0;
        logic [31:0] result1;
        logic [31:0] result2;
        logic [31:0] result3;
        logic [2:0]  lanes_valid;
    } out_t;

    typedef struct packed {
        logic calc;
        logic commit;
        logic first;
    } lane_ctl_t;

    function automatic logic f32_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // Ordered less-than for two non-NaN values; +0 and -0 compare equal.
    function automatic logic f32_lt(input logic [31:0] x, input logic [31:0] y);
        logic both_zero;
        both_zero = (x[30:0] == 31'd0) && (y[30:0] == 31'd0);
        if (both_zero)
        begin
            return 1'b0;
        end
        if (x[31] != y[31])
        begin
            return x[31];
        end
        if (!x[31])
        begin
            return x[30:0] < y[30:0];
        end
        return x[30:0] > y[30:0];
    endfunction

endpackage

/* hdl/bfdp_lane.sv */
// One column lane: two-stage fp32 fused multiply-add into the lane accumulator.
module bfdp_lane
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfdp_pkg::lane_ctl_t   ctl,
    input  logic [15:0]           activation,
    input  logic [15:0]           weight,
    input  logic [31:0]           bias,
    output logic [31:0]           acc
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;

    logic [52:0]        sum_reg;
    logic [52:0]        sum_next;
    logic signed [10:0] expa_reg;
    logic signed [10:0] expa_next;
    logic               sign_reg;
    logic               sign_next;
    logic               nan_reg;
    logic               nan_next;
    logic               inf_reg;
    logic               inf_next;

    // ---------------- stage one: multiply, align and add ----------------
    logic [31:0]        c_op;
    logic [7:0]         ea, eb, ec_e, ea_e, eb_e;
    logic [7:0]         ma, mb;
    logic [15:0]        mp;
    logic [23:0]        m_p, m_c, m_a, m_b;
    logic signed [10:0] e_p, e_c, e_a, e_b, exp_gap;
    logic               s_p, s_c, s_a, s_b;
    logic               z_p, z_c, sel_p;
    logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan, c_inf, c_nan;
    logic               p_nan, p_inf;
    logic [6:0]         shamt;
    logic [102:0]       wide_b;
    logic [51:0]        x_op, y_op;
    logic [52:0]        sum_raw;
    logic               add_sign;

    assign c_op = ctl.first ? bias : acc_reg;
    assign ea   = activation[14:7];
    assign eb   = weight[14:7];
    assign ea_e = (ea == 8'd0) ? 8'd1 : ea;
    assign eb_e = (eb == 8'd0) ? 8'd1 : eb;
    assign ec_e = (c_op[30:23] == 8'd0) ? 8'd1 : c_op[30:23];
    assign ma   = {ea != 8'd0, activation[6:0]};
    assign mb   = {eb != 8'd0, weight[6:0]};
    assign mp   = ma * mb;
    assign m_p  = {mp, 8'h00};
    assign m_c  = {c_op[30:23] != 8'd0, c_op[22:0]};
    assign s_p  = activation[15] ^ weight[15];
    assign s_c  = c_op[31];
    // Exponents are the weights of each significand's least significant bit.
    assign e_p  = $signed({3'b000, ea_e}) + $signed({3'b000, eb_e}) - 11'sd276;
    assign e_c  = $signed({3'b000, ec_e}) - 11'sd150;
    assign z_p  = (mp == 16'd0);
    assign z_c  = (m_c == 24'd0);

    assign a_zero = (activation[14:0] == 15'd0);
    assign b_zero = (weight[14:0] == 15'd0);
    assign a_inf  = (ea == 8'hFF) && (activation[6:0] == 7'd0);
    assign b_inf  = (eb == 8'hFF) && (weight[6:0] == 7'd0);
    assign a_nan  = (ea == 8'hFF) && (activation[6:0] != 7'd0);
    assign b_nan  = (eb == 8'hFF) && (weight[6:0] != 7'd0);
    assign c_inf  = (c_op[30:23] == 8'hFF) && (c_op[22:0] == 23'd0);
    assign c_nan  = bfdp_pkg::f32_is_nan(c_op);
    assign p_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    assign p_inf  = (a_inf || b_inf) && !p_nan;

    // The operand with the coarser least significant bit is kept whole.
    assign sel_p   = z_c || (!z_p && (e_p > e_c));
    assign m_a     = sel_p ? m_p : m_c;
    assign e_a     = sel_p ? e_p : e_c;
    assign s_a     = sel_p ? s_p : s_c;
    assign m_b     = sel_p ? m_c : m_p;
    assign e_b     = sel_p ? e_c : e_p;
    assign s_b     = sel_p ? s_c : s_p;
    assign exp_gap = e_a - e_b;

    always_comb
    begin
        if (exp_gap[10])
        begin
            shamt = 7'd0;
        end
        else if (exp_gap > 11'sd79)
        begin
            shamt = 7'd79;
        end
        else
        begin
            shamt = exp_gap[6:0];
        end
    end

    assign wide_b = {m_b, 79'd0} >> shamt;
    assign x_op   = {m_a, 28'd0};
    assign y_op   = {wide_b[102:52], |wide_b[51:0]};

    always_comb
    begin
        if (s_a == s_b)
        begin
            sum_raw  = {1'b0, x_op} + {1'b0, y_op};
            add_sign = s_a;
        end
        else if (x_op >= y_op)
        begin
            sum_raw  = {1'b0, x_op - y_op};
            add_sign = s_a;
        end
        else
        begin
            sum_raw  = {1'b0, y_op - x_op};
            add_sign = s_b;
        end
    end

    always_comb
    begin
        nan_next  = p_nan || c_nan || (p_inf && c_inf && (s_p != s_c));
        inf_next  = !nan_next && (p_inf || c_inf);
        sum_next  = sum_raw;
        expa_next = e_a;
        if (inf_next)
        begin
            sign_next = p_inf ? s_p : s_c;
        end
        else if (sum_raw == 53'd0)
        begin
            // An exact cancellation gives +0; two zero terms keep a shared sign.
            sign_next = z_p && z_c && s_p && s_c;
        end
        else
        begin
            sign_next = add_sign;
        end
    end

    // ---------------- stage two: normalise and round ----------------
    logic [5:0]         lz;
    logic signed [10:0] lim, lz_s, be, e_out;
    logic               normal;
    logic [5:0]         lshamt;
    logic [6:0]         rshamt;
    logic [52:0]        norm_l;
    logic [116:0]       wide_r;
    logic [52:0]        norm;
    logic               rsticky;
    logic [23:0]        mant;
    logic               guard, sticky, inc;
    logic [24:0]        m_rnd;
    logic [31:0]        rounded;

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 53; i++)
        begin
            if (sum_reg[i])
            begin
                lz = 6'(52 - i);
            end
        end
    end

    // lim is the left shift that puts the smallest subnormal step at the round point.
    assign lim    = expa_reg + 11'sd150;
    assign lz_s   = $signed({5'b00000, lz});
    assign normal = (lim >= lz_s);
    assign lshamt = normal ? lz : lim[5:0];
    assign rshamt = (lim < -11'sd63) ? 7'd63 : 7'(-lim);
    assign norm_l = sum_reg << lshamt;
    assign wide_r = {sum_reg, 64'd0} >> rshamt;

    always_comb
    begin
        if (lim[10])
        begin
            norm    = wide_r[116:64];
            rsticky = |wide_r[63:0];
        end
        else
        begin
            norm    = norm_l;
            rsticky = 1'b0;
        end
    end

    assign mant   = norm[52:29];
    assign guard  = norm[28];
    assign sticky = (|norm[27:0]) || rsticky;
    assign inc    = guard && (sticky || mant[0]);
    assign m_rnd  = {1'b0, mant} + {24'd0, inc};
    assign be     = expa_reg + 11'sd151 - lz_s;
    assign e_out  = be + $signed({10'd0, m_rnd[24]});

    always_comb
    begin
        if (nan_reg)
        begin
            rounded = bfdp_pkg::F32_QNAN;
        end
        else if (inf_reg)
        begin
            rounded = {sign_reg, 8'hFF, 23'd0};
        end
        else if (sum_reg == 53'd0)
        begin
            rounded = {sign_reg, 31'd0};
        end
        else if (normal)
        begin
            if (e_out >= 11'sd255)
            begin
                rounded = {sign_reg, 8'hFF, 23'd0};
            end
            else
            begin
                rounded = {sign_reg, e_out[7:0], m_rnd[24] ? m_rnd[23:1] : m_rnd[22:0]};
            end
        end
        else
        begin
            // A carry out of a subnormal significand lands on the smallest normal.
            rounded = {sign_reg, 7'd0, m_rnd[23], m_rnd[22:0]};
        end
    end

    assign acc_next = ctl.commit ? rounded : acc_reg;
    assign acc      = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 32'd0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            sum_reg  <= sum_next;
            expa_reg <= expa_next;
            sign_reg <= sign_next;
            nan_reg  <= nan_next;
            inf_reg  <= inf_next;
        end
    end

endmodule

/* hdl/bfdp_clamp.sv */
// Merging stage: clamps every lane and holds the result for the output channel.
module bfdp_clamp
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic                                    out_stall,
    input  logic [bfdp_pkg::NUM_LANES-1:0][31:0]    acc,
    input  logic [31:0]                             min_clamp,
    input  logic [31:0]                             max_clamp,
    input  logic [2:0]                              lane_count,
    output logic                                    out_valid,
    output bfdp_pkg::out_t                          out_data
);

    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    bfdp_pkg::out_t                         out_data_reg;
    bfdp_pkg::out_t                         out_data_next;
    logic [bfdp_pkg::NUM_LANES-1:0][31:0]   clamped;

    always_comb
    begin
        logic [31:0] lo_v;
        logic [31:0] hi_v;
        for (int i = 0; i < bfdp_pkg::NUM_LANES; i++)
        begin
            // A NaN on one side of a compare yields the other side.
            if (bfdp_pkg::f32_is_nan(acc[i]))
            begin
                lo_v = min_clamp;
            end
            else if (bfdp_pkg::f32_is_nan(min_clamp))
            begin
                lo_v = acc[i];
            end
            else
            begin
                lo_v = bfdp_pkg::f32_lt(min_clamp, acc[i]) ? acc[i] : min_clamp;
            end

            if (bfdp_pkg::f32_is_nan(lo_v))
            begin
                hi_v = max_clamp;
            end
            else if (bfdp_pkg::f32_is_nan(max_clamp))
            begin
                hi_v = lo_v;
            end
            else
            begin
                hi_v = bfdp_pkg::f32_lt(max_clamp, lo_v) ? max_clamp : lo_v;
            end

            clamped[i] = bfdp_pkg::f32_is_nan(hi_v) ? bfdp_pkg::F32_QNAN : hi_v;
        end
    end

    always_comb
    begin
        out_data_next             = out_data_reg;
        out_valid_next            = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.result0       = clamped[0];
            out_data_next.result1       = clamped[1];
            out_data_next.result2       = clamped[2];
            out_data_next.result3       = clamped[3];
            out_data_next.lanes_valid   = lane_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hdl/bf16_dot_product_clamp_4col_core.sv */
// Top level of the bf16 dot product core with fp32 accumulation and clamp.
//
// Input channel in_valid/in_stall/in_data: one transfer per reduction step,
// carrying one bf16 activation, four bf16 weights and, with first, four fp32
// biases and the number of columns in use. Output channel
// out_valid/out_stall/out_data: one transfer per run, after its last item,
// carrying four clamped fp32 results and lanes_valid.
// Each of the four lanes runs a two-stage fused multiply-add (align and add,
// then normalise and round) that feeds its own accumulator, so a new item is
// taken only when the lanes commit the one before. A last item passes the lane
// stage registers, the accumulators and the clamp stage's register behind out_valid.
// The clamp bounds are written through cfg_wr_en/cfg_index/cfg_data; the user must do
// so only while the core is idle, which is not enforced. Reset sets them to minus
// and plus infinity, clears the accumulators to +0 and sets the column count to four.
// A stalled output holds its data; the lanes keep working, and only the
// commit of a further item waits until the clamp stage has handed its result on.
module bf16_dot_product_clamp_4col_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bfdp_pkg::in_t       in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bfdp_pkg::out_t      out_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

`include "bf16_dot_product_clamp_4col_core_macros.svh"

    bfdp_pkg::in_t  in_reg;
    logic           ivld_reg, ivld_next;
    logic           phase_reg, phase_next;
    logic           pend_reg, pend_next;
    logic [2:0]     count_reg, count_next;
    logic [31:0]    min_reg, min_next;
    logic [31:0]    max_reg, max_next;

    logic                                   accept;
    logic                                   commit;
    logic                                   clamp_go;
    logic [2:0]                             count_sat;
    bfdp_pkg::lane_ctl_t                    lane_ctl;
    logic [bfdp_pkg::NUM_LANES-1:0][15:0]   weights;
    logic [bfdp_pkg::NUM_LANES-1:0][31:0]   biases;
    logic [bfdp_pkg::NUM_LANES-1:0][31:0]   accs;

    assign commit   = ivld_reg && phase_reg && !pend_reg;
    assign in_stall = ivld_reg && !commit;
    assign accept   = in_valid && !in_stall;
    assign clamp_go = pend_reg && (!out_valid || !out_stall);

    assign lane_ctl.calc   = ivld_reg && !phase_reg;
    assign lane_ctl.commit = commit;
    assign lane_ctl.first  = in_reg.first;

    assign weights = {in_reg.weight3, in_reg.weight2, in_reg.weight1, in_reg.weight0};
    assign biases  = {in_reg.bias3, in_reg.bias2, in_reg.bias1, in_reg.bias0};

    always_comb
    begin
        if (in_reg.lanes_in_use == 3'd0)
        begin
            count_sat = 3'd1;
        end
        else if (in_reg.lanes_in_use > 3'(bfdp_pkg::NUM_LANES))
        begin
            count_sat = 3'(bfdp_pkg::NUM_LANES);
        end
        else
        begin
            count_sat = in_reg.lanes_in_use;
        end
    end

    always_comb
    begin
        ivld_next  = ivld_reg;
        phase_next = phase_reg;
        if (lane_ctl.calc)
        begin
            phase_next = 1'b1;
        end
        if (commit)
        begin
            ivld_next = 1'b0;
        end
        if (accept)
        begin
            ivld_next  = 1'b1;
            phase_next = 1'b0;
        end

        pend_next = pend_reg;
        if (commit && in_reg.last)
        begin
            pend_next = 1'b1;
        end
        else if (clamp_go)
        begin
            pend_next = 1'b0;
        end

        count_next = (commit && in_reg.first) ? count_sat : count_reg;

        min_next = min_reg;
        max_next = max_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bfdp_pkg::CFG_MIN_CLAMP: min_next = cfg_data;
                bfdp_pkg::CFG_MAX_CLAMP: max_next = cfg_data;
                default:                 min_next = min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg  <= 1'b0;
            phase_reg <= 1'b0;
            pend_reg  <= 1'b0;
            count_reg <= 3'(bfdp_pkg::NUM_LANES);
            min_reg   <= bfdp_pkg::MIN_CLAMP_RESET;
            max_reg   <= bfdp_pkg::MAX_CLAMP_RESET;
        end
        else
        begin
            ivld_reg  <= ivld_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
    end

    for (genvar g = 0; g < bfdp_pkg::NUM_LANES; g++)
    begin : g_lane
        bfdp_lane u_lane
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .activation (in_reg.activation),
            .weight     (weights[g]),
            .bias       (biases[g]),
            .acc        (accs[g])
        );
    end

    bfdp_clamp u_clamp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (clamp_go),
        .out_stall  (out_stall),
        .acc        (accs),
        .min_clamp  (min_reg),
        .max_clamp  (max_reg),
        .lane_count (count_reg),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

    `BFDP_ASSERT_IMPL(a_accept_frees_slot, in_valid && !in_stall && ivld_reg, commit)
    `BFDP_ASSERT_NEXT(a_last_raises_pend, commit && in_reg.last, pend_reg)
    `BFDP_ASSERT_IMPL(a_count_in_range, out_valid, out_data.lanes_valid != 3'd0 && out_data.lanes_valid <= 3'(bfdp_pkg::NUM_LANES))

endmodule
